// ===== hdl/eafc_pkg.sv =====
// ----------------------------------------------------------------------------
// eafc_pkg
// Shared types and constants for the encoder angle frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package eafc_pkg;

    // frame layout: command echo, angle high, angle low, status, CRC
    localparam int FrameLength = 5;
    localparam int PosWidth    = 3;

    // CRC and parity constants
    localparam logic [7:0] CrcTopBit      = 8'h80;
    localparam logic [7:0] ParityDataMask = 8'hFE;
    localparam logic [7:0] ParityBit      = 8'h01;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CRC_SEED      = 3'd0,
        REG_CRC_POLY      = 3'd1,
        REG_CRC_FINAL_XOR = 3'd2,
        REG_MAGNET_MASK   = 3'd3,
        REG_ATTEMPT_LIMIT = 3'd4
    } cfg_index_t;

    // configuration reset values (SAE J1850 CRC by default)
    localparam logic [7:0] CrcSeedReset      = 8'hFF;
    localparam logic [7:0] CrcPolyReset      = 8'h1D;
    localparam logic [7:0] CrcFinalXorReset  = 8'hFF;
    localparam logic [7:0] MagnetMaskReset   = 8'h02;
    localparam logic [3:0] AttemptLimitReset = 4'd6;

    // frame outcome codes
    typedef enum logic [1:0] {
        OUT_VALID      = 2'd0,
        OUT_PARITY_ERR = 2'd1,
        OUT_CRC_RETRY  = 2'd2,
        OUT_GAVE_UP    = 2'd3
    } outcome_t;

    // result beat, last member in the lowest bits
    typedef struct packed {
        logic [3:0]  attempt_number;
        outcome_t    outcome;
        logic        magnet_fault;
        logic        parity_good;
        logic        crc_good;
        logic [7:0]  received_crc;
        logic [7:0]  status_byte;
        logic [15:0] angle_raw;
    } result_t;

    localparam int ResultWidth = $bits(result_t);
    localparam int TdataWidth  = ((ResultWidth + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== hdl/encoder_angle_frame_checker.sv =====
// ----------------------------------------------------------------------------
// encoder_angle_frame_checker
// Collects a five-byte encoder reply, checks CRC-8, parity and magnet status,
// and tracks CRC retries up to a configurable limit.
// ----------------------------------------------------------------------------
//  Channel   Dir   Beat contents
//  s_*       in    tdata: rx_byte; tuser: frame_start
//  m_*       out   tdata: angle, status, CRC, flags, outcome, attempt
//  cfg_*     in    register write, index + data, no read-back
//
//  One byte per cycle; a result is registered and leaves in the cycle after the CRC byte is taken.
//  The byte path is one unrolled CRC-8 step between the frame registers.
//  Reset is synchronous: frame closed, failure count cleared, registers at
//  their defaults. s_tready drops only while a result waits on a stalled m_*.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_angle_frame_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // rx_byte [7:0]
    input  wire logic [7:0]                      s_tdata,
    // frame_start [0]
    input  wire logic                            s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // angle_raw [15:0], status_byte [23:16], received_crc [31:24],
    // crc_good [32], parity_good [33], magnet_fault [34], outcome [36:35],
    // attempt_number [40:37], zero fill above
    output logic [eafc_pkg::TdataWidth-1:0]      m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_we,
    input  wire logic [2:0]                      cfg_index,
    input  wire logic [7:0]                      cfg_data
);
    import eafc_pkg::*;

    localparam logic [PosWidth-1:0] PosIdle = '0;
    localparam logic [PosWidth-1:0] PosHigh = PosWidth'(1);
    localparam logic [PosWidth-1:0] PosLow  = PosWidth'(2);
    localparam logic [PosWidth-1:0] PosCrc  = PosWidth'(FrameLength - 1);

    // configuration registers
    logic [7:0] crc_seed_reg, crc_poly_reg, crc_final_xor_reg, magnet_mask_reg;
    logic [3:0] attempt_limit_reg;

    // frame state
    logic [PosWidth-1:0] pos_reg, pos_next;
    logic [7:0]          crc_reg, crc_next;
    logic [7:0]          angle_high_reg, angle_high_next;
    logic [7:0]          angle_low_reg, angle_low_next;
    logic [7:0]          status_reg, status_next;
    logic [3:0]          failed_reg, failed_next;

    // output stage
    result_t result_reg, result_next;
    logic    m_valid_reg, m_valid_next;

    logic       in_beat;
    logic [7:0] crc_step;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TdataWidth'(result_reg);

    eafc_crc8_step u_crc (
        .crc_in  (crc_reg),
        .data_in (s_tdata),
        .poly    (crc_poly_reg),
        .crc_out (crc_step)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_seed_reg      <= CrcSeedReset;
            crc_poly_reg      <= CrcPolyReset;
            crc_final_xor_reg <= CrcFinalXorReset;
            magnet_mask_reg   <= MagnetMaskReset;
            attempt_limit_reg <= AttemptLimitReset;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CRC_SEED:      crc_seed_reg      <= cfg_data;
                REG_CRC_POLY:      crc_poly_reg      <= cfg_data;
                REG_CRC_FINAL_XOR: crc_final_xor_reg <= cfg_data;
                REG_MAGNET_MASK:   magnet_mask_reg   <= cfg_data;
                REG_ATTEMPT_LIMIT: attempt_limit_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // frame tracking and result build
    always_comb begin
        logic [3:0] limit;
        logic [4:0] tries;
        logic       crc_ok;
        logic       par_match;
        logic       mag;
        logic [7:0] status_par;

        pos_next        = pos_reg;
        crc_next        = crc_reg;
        angle_high_next = angle_high_reg;
        angle_low_next  = angle_low_reg;
        status_next     = status_reg;
        failed_next     = failed_reg;
        result_next     = result_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        crc_ok     = ((crc_reg ^ crc_final_xor_reg) == s_tdata);
        status_par = status_reg & ParityDataMask;
        par_match  = ((^{angle_high_reg, angle_low_reg, status_par})
                      == ((status_reg & ParityBit) != 8'h00));
        mag        = ((status_reg & magnet_mask_reg) != 8'h00);
        limit      = (attempt_limit_reg == 4'd0) ? 4'd1 : attempt_limit_reg;
        tries      = {1'b0, failed_reg} + 5'd1;

        if (in_beat) begin
            priority if (s_tuser) begin
                pos_next = PosHigh;
                crc_next = crc_seed_reg;
            end else if (pos_reg == PosIdle) begin
                // stray byte outside a frame
            end else if (pos_reg != PosCrc) begin
                if (pos_reg == PosHigh) begin
                    angle_high_next = s_tdata;
                end else if (pos_reg == PosLow) begin
                    angle_low_next = s_tdata;
                end else begin
                    status_next = s_tdata;
                end
                crc_next = crc_step;
                pos_next = pos_reg + PosWidth'(1);
            end else begin
                // CRC byte closes the frame
                pos_next                   = PosIdle;
                m_valid_next               = 1'b1;
                result_next.angle_raw      = {angle_high_reg, angle_low_reg};
                result_next.status_byte    = status_reg;
                result_next.received_crc   = s_tdata;
                result_next.crc_good       = crc_ok;
                result_next.parity_good    = par_match;
                result_next.magnet_fault   = mag;
                result_next.attempt_number = tries[3:0];
                priority if (crc_ok) begin
                    result_next.outcome = par_match ? OUT_VALID : OUT_PARITY_ERR;
                    failed_next         = 4'd0;
                end else if (tries >= {1'b0, limit}) begin
                    result_next.outcome      = OUT_GAVE_UP;
                    result_next.angle_raw    = 16'h0000;
                    result_next.status_byte  = 8'h00;
                    result_next.received_crc = 8'h00;
                    result_next.crc_good     = 1'b0;
                    result_next.parity_good  = 1'b0;
                    result_next.magnet_fault = 1'b0;
                    failed_next              = 4'd0;
                end else begin
                    result_next.outcome = OUT_CRC_RETRY;
                    failed_next         = tries[3:0];
                end
            end
        end
    end

    // state and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= PosIdle;
            crc_reg        <= CrcSeedReset;
            angle_high_reg <= 8'h00;
            angle_low_reg  <= 8'h00;
            status_reg     <= 8'h00;
            failed_reg     <= 4'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            angle_high_reg <= angle_high_next;
            angle_low_reg  <= angle_low_next;
            status_reg     <= status_next;
            failed_reg     <= failed_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ===== hdl/eafc_crc8_step.sv =====
// ----------------------------------------------------------------------------
// eafc_crc8_step
// One byte of a configurable MSB-first CRC-8, unrolled over eight bits.
// ----------------------------------------------------------------------------
`default_nettype none

module eafc_crc8_step (
    input  wire logic [7:0] crc_in,
    input  wire logic [7:0] data_in,
    input  wire logic [7:0] poly,
    output logic      [7:0] crc_out
);
    import eafc_pkg::*;

    // shift eight bits, folding in the polynomial on a set top bit
    always_comb begin
        logic [7:0] c;
        c = crc_in ^ data_in;
        for (int k = 0; k < 8; k++) begin
            if ((c & CrcTopBit) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire
